@@ rtl/core/obrot_pkg.sv @@
// ----------------------------------------------------------------------------
// obrot_pkg
// Types, widths and rounding helpers for the oblique point rotation block.
// ----------------------------------------------------------------------------
package obrot_pkg;

	localparam int COEF_W  = 16;
	localparam int POS_W   = 18;
	localparam int LINE_W  = 19;
	localparam int SLICE_W = 12;
	localparam int OUT_W   = 20;
	localparam int CFG_W   = 18;
	localparam int IDX_W   = 3;

	localparam int DXY_W   = 20;
	localparam int DZ_W    = 21;
	localparam int XC_W    = 18;
	localparam int PROD_W  = 40;
	localparam int RND_W   = PROD_W - 14;
	localparam int SUM_W   = 28;
	localparam int FRAC_W  = 14;

	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic        [POS_W-1:0]   pos_t;
	typedef logic signed [LINE_W-1:0]  line_t;
	typedef logic signed [SLICE_W-1:0] slice_t;
	typedef logic signed [OUT_W-1:0]   out_t;
	typedef logic        [CFG_W-1:0]   cfg_data_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [RND_W-1:0]   rnd_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	typedef enum logic [IDX_W-1:0] {
		REG_COS_CORONAL = 3'd0,
		REG_SIN_CORONAL = 3'd1,
		REG_COS_AXIAL   = 3'd2,
		REG_SIN_AXIAL   = 3'd3,
		REG_CENTER_X    = 3'd4,
		REG_CENTER_Y    = 3'd5,
		REG_PIVOT_Z     = 3'd6
	} cfg_idx_t;

	localparam coef_t COS_RST   = 16'sd16384;
	localparam coef_t SIN_RST   = 16'sd0;
	localparam pos_t  CENTER_RST = 18'd32768;
	localparam pos_t  PIVOT_RST  = 18'd0;

	localparam prod_t RND_HALF = prod_t'(1) <<< (FRAC_W - 1);
	localparam sum_t  OUT_MAX  = sum_t'(524287);
	localparam sum_t  OUT_MIN  = -sum_t'(524288);

	// round to nearest by 14 bits, halves toward +inf
	function automatic rnd_t rnd14(input prod_t v);
		prod_t t;
		t = v + RND_HALF;
		return t[PROD_W-1:FRAC_W];
	endfunction

	function automatic out_t sat_out(input sum_t v);
		out_t r;
		if (v > OUT_MAX) begin
			r = OUT_MAX[OUT_W-1:0];
		end else if (v < OUT_MIN) begin
			r = OUT_MIN[OUT_W-1:0];
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/core/oblique_point_rotate_3d_top.sv @@
// ----------------------------------------------------------------------------
// oblique_point_rotate_3d_top
// Rotates a sample point about a pivot by a coronal and an axial angle.
// ----------------------------------------------------------------------------
// Usage
//   A point (line_x, line_y, slice_z) is taken at a clock edge where start is
//   high and busy is low. busy stays low: a point can be taken every cycle.
//   The rotated point appears on rot_x, rot_y, rot_z for exactly one cycle,
//   marked by done, after passing the s1 to s4 registers below. Throughput is
//   one point per cycle, set by the four-stage multiply pipeline:
//     s1: offsets from the pivot, coronal-by-axial cross products
//     s2: cross coefficients rounded, eight offset products
//     s3: products rounded and summed with the pivot
//     s4: saturation into the output register
//   Angles and pivot are loaded through cfg_we / cfg_idx / cfg_wdata; the user
//   must load them only while no point is in flight, which the block does not
//   enforce; indexes beyond six are ignored. Reset clears the pipeline valid
//   bits and loads identity angles with the pivot at (128.0, 128.0, 0). The
//   receiver cannot stall: every result beat is presented once and is gone the next cycle.
// ----------------------------------------------------------------------------
module oblique_point_rotate_3d_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  obrot_pkg::line_t    line_x,
	input  obrot_pkg::line_t    line_y,
	input  obrot_pkg::slice_t   slice_z,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  obrot_pkg::cfg_data_t cfg_wdata,
	output logic                done,
	output obrot_pkg::out_t     rot_x,
	output obrot_pkg::out_t     rot_y,
	output obrot_pkg::out_t     rot_z
);
	import obrot_pkg::*;

	coef_t cos_cor_q, sin_cor_q, cos_ax_q, sin_ax_q;
	pos_t  center_x_q, center_y_q, pivot_z_q;

	logic                     in_fire;
	logic signed [DXY_W-1:0]  dx_d, dy_d;
	logic signed [DZ_W-1:0]   dz_d;

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic signed [DXY_W-1:0]  dx_s1, dy_s1;
	logic signed [DZ_W-1:0]   dz_s1;
	prod_t                    ccsa_s1, scsa_s1, scca_s1, ccca_s1;

	rnd_t                     ccsa_r, scsa_r, scca_r, ccca_r;
	logic signed [XC_W-1:0]   ccsa_c, scsa_c, scca_c, ccca_c;
	prod_t                    p_dx_ca_s2, p_dz_ccsa_s2, p_dy_scsa_s2;
	prod_t                    p_dy_cc_s2, p_dz_sc_s2;
	prod_t                    p_dx_sa_s2, p_dy_scca_s2, p_dz_ccca_s2;

	sum_t                     rx_s3, ry_s3, rz_s3;
	out_t                     rx_s4, ry_s4, rz_s4;

	assign busy    = 1'b0;
	assign in_fire = start & ~busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_cor_q  <= COS_RST;
			sin_cor_q  <= SIN_RST;
			cos_ax_q   <= COS_RST;
			sin_ax_q   <= SIN_RST;
			center_x_q <= CENTER_RST;
			center_y_q <= CENTER_RST;
			pivot_z_q  <= PIVOT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_COS_CORONAL: cos_cor_q  <= cfg_wdata[COEF_W-1:0];
				REG_SIN_CORONAL: sin_cor_q  <= cfg_wdata[COEF_W-1:0];
				REG_COS_AXIAL:   cos_ax_q   <= cfg_wdata[COEF_W-1:0];
				REG_SIN_AXIAL:   sin_ax_q   <= cfg_wdata[COEF_W-1:0];
				REG_CENTER_X:    center_x_q <= cfg_wdata[POS_W-1:0];
				REG_CENTER_Y:    center_y_q <= cfg_wdata[POS_W-1:0];
				REG_PIVOT_Z:     pivot_z_q  <= cfg_wdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// offsets from the pivot
	always_comb begin
		dx_d = $signed({line_x[LINE_W-1], line_x}) - $signed({2'b00, center_x_q});
		dy_d = $signed({line_y[LINE_W-1], line_y}) - $signed({2'b00, center_y_q});
		dz_d = $signed({slice_z[SLICE_W-1], slice_z, 8'd0}) - $signed({3'b000, pivot_z_q});
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// s1: offsets and raw cross products
	always_ff @(posedge clk) begin
		if (in_fire) begin
			dx_s1   <= dx_d;
			dy_s1   <= dy_d;
			dz_s1   <= dz_d;
			ccsa_s1 <= prod_t'(cos_cor_q) * prod_t'(sin_ax_q);
			scsa_s1 <= prod_t'(sin_cor_q) * prod_t'(sin_ax_q);
			scca_s1 <= prod_t'(sin_cor_q) * prod_t'(cos_ax_q);
			ccca_s1 <= prod_t'(cos_cor_q) * prod_t'(cos_ax_q);
		end
	end

	// rounded cross coefficients
	always_comb begin
		ccsa_r = rnd14(ccsa_s1);
		scsa_r = rnd14(scsa_s1);
		scca_r = rnd14(scca_s1);
		ccca_r = rnd14(ccca_s1);
		ccsa_c = ccsa_r[XC_W-1:0];
		scsa_c = scsa_r[XC_W-1:0];
		scca_c = scca_r[XC_W-1:0];
		ccca_c = ccca_r[XC_W-1:0];
	end

	// s2: offset products
	always_ff @(posedge clk) begin
		if (v_s1) begin
			p_dx_ca_s2   <= prod_t'(dx_s1) * prod_t'(cos_ax_q);
			p_dz_ccsa_s2 <= prod_t'(dz_s1) * prod_t'(ccsa_c);
			p_dy_scsa_s2 <= prod_t'(dy_s1) * prod_t'(scsa_c);
			p_dy_cc_s2   <= prod_t'(dy_s1) * prod_t'(cos_cor_q);
			p_dz_sc_s2   <= prod_t'(dz_s1) * prod_t'(sin_cor_q);
			p_dx_sa_s2   <= prod_t'(dx_s1) * prod_t'(sin_ax_q);
			p_dy_scca_s2 <= prod_t'(dy_s1) * prod_t'(scca_c);
			p_dz_ccca_s2 <= prod_t'(dz_s1) * prod_t'(ccca_c);
		end
	end

	// s3: round and sum
	always_ff @(posedge clk) begin
		if (v_s2) begin
			rx_s3 <= sum_t'(rnd14(p_dx_ca_s2)) + sum_t'(rnd14(p_dz_ccsa_s2))
			       - sum_t'(rnd14(p_dy_scsa_s2)) + $signed({10'd0, center_x_q});
			ry_s3 <= sum_t'(rnd14(p_dy_cc_s2)) + sum_t'(rnd14(p_dz_sc_s2))
			       + $signed({10'd0, center_y_q});
			rz_s3 <= sum_t'(rnd14(p_dz_ccca_s2)) - sum_t'(rnd14(p_dx_sa_s2))
			       - sum_t'(rnd14(p_dy_scca_s2)) + $signed({10'd0, pivot_z_q});
		end
	end

	// s4: saturate into output register
	always_ff @(posedge clk) begin
		if (v_s3) begin
			rx_s4 <= sat_out(rx_s3);
			ry_s4 <= sat_out(ry_s3);
			rz_s4 <= sat_out(rz_s3);
		end
	end

	assign done  = v_s4;
	assign rot_x = rx_s4;
	assign rot_y = ry_s4;
	assign rot_z = rz_s4;

	// every result beat comes from a point taken through the s1 to s4 registers
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(in_fire, 4))
		else $error("result beat without a matching input beat");

	// every point taken out of reset yields a result beat
	a_source_has_done: assert property (@(posedge clk) disable iff (!arst_n)
		($past(in_fire, 4) && $past(arst_n, 1) && $past(arst_n, 2)
		 && $past(arst_n, 3) && $past(arst_n, 4)) |-> done)
		else $error("input beat lost in the pipeline");

	// the pipeline never refuses a point
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("start refused");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for oblique_point_rotate_3d_top.
// A driver sends points and register writes from a queue that the stimulus
// block fills, and a monitor checks every result beat against an internal
// fixed-point model of the rotation. Register writes happen only once the
// pipeline has drained. Directed corner points and settings come first, then
// random phases with fresh angles and pivots and random idle bursts.
// ----------------------------------------------------------------------------
module tb_top;

	import obrot_pkg::*;

	localparam int          CLK_HALF    = 5;
	localparam int          DRAIN       = 10;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          N_PHASES    = 13;
	localparam int          PHASE_PTS   = 130;
	localparam int          PRINT_CAP   = 100;
	localparam logic [2:0]  IDX_SPARE   = 3'd7;
	localparam longint      SAT_HI      = 524287;
	localparam longint      SAT_LO      = -524288;

	typedef struct {
		logic        is_cfg;
		logic [2:0]  idx;
		cfg_data_t   wdata;
		line_t       lx;
		line_t       ly;
		slice_t      sz;
		int unsigned pre_gap;
	} beat_t;

	typedef struct packed {
		out_t x;
		out_t y;
		out_t z;
	} coord_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        busy;
	line_t       line_x    = '0;
	line_t       line_y    = '0;
	slice_t      slice_z   = '0;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_idx   = '0;
	cfg_data_t   cfg_wdata = '0;
	logic        done;
	out_t        rot_x;
	out_t        rot_y;
	out_t        rot_z;

	beat_t       feed_q[$];
	coord_t      rot_expect_q[$];

	// register copies held by the predictor
	coef_t       m_cos_cor = COS_RST;
	coef_t       m_sin_cor = SIN_RST;
	coef_t       m_cos_ax  = COS_RST;
	coef_t       m_sin_ax  = SIN_RST;
	pos_t        m_cx      = CENTER_RST;
	pos_t        m_cy      = CENTER_RST;
	pos_t        m_pz      = PIVOT_RST;

	int unsigned gap_left   = 0;
	logic        gap_done   = 1'b0;
	int unsigned since_beat = 0;
	int unsigned n_points   = 0;
	int unsigned n_writes   = 0;
	int unsigned n_results  = 0;
	int unsigned n_errors   = 0;
	int unsigned cycle_cnt  = 0;

	oblique_point_rotate_3d_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.line_x   (line_x),
		.line_y   (line_y),
		.slice_z  (slice_z),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.done     (done),
		.rot_x    (rot_x),
		.rot_y    (rot_y),
		.rot_z    (rot_z)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// ---------------------------------------------------------------- model
	function automatic longint round_q14(input longint v);
		return (v + 64'sd8192) >>> 14;
	endfunction

	function automatic out_t clamp_out(input longint v);
		if (v > SAT_HI) begin
			return out_t'(SAT_HI);
		end
		if (v < SAT_LO) begin
			return out_t'(SAT_LO);
		end
		return out_t'(v);
	endfunction

	function automatic coord_t rotate_point(input line_t lx, input line_t ly, input slice_t sz);
		longint cc, sc, ca, sa, cx, cy, pz;
		longint dx, dy, dz, cc_sa, sc_sa, sc_ca, cc_ca;
		coord_t r;
		cc = longint'(m_cos_cor);
		sc = longint'(m_sin_cor);
		ca = longint'(m_cos_ax);
		sa = longint'(m_sin_ax);
		cx = longint'(m_cx);
		cy = longint'(m_cy);
		pz = longint'(m_pz);
		dx = longint'(lx) - cx;
		dy = longint'(ly) - cy;
		dz = longint'(sz) * 256 - pz;
		cc_sa = round_q14(cc * sa);
		sc_sa = round_q14(sc * sa);
		sc_ca = round_q14(sc * ca);
		cc_ca = round_q14(cc * ca);
		r.x = clamp_out(round_q14(dx * ca) + round_q14(dz * cc_sa) - round_q14(dy * sc_sa) + cx);
		r.y = clamp_out(round_q14(dy * cc) + round_q14(dz * sc) + cy);
		r.z = clamp_out(-round_q14(dx * sa) - round_q14(dy * sc_ca) + round_q14(dz * cc_ca) + pz);
		return r;
	endfunction

	task automatic apply_write(input logic [2:0] idx, input cfg_data_t d);
		case (idx)
			REG_COS_CORONAL: m_cos_cor = coef_t'(d[COEF_W-1:0]);
			REG_SIN_CORONAL: m_sin_cor = coef_t'(d[COEF_W-1:0]);
			REG_COS_AXIAL:   m_cos_ax  = coef_t'(d[COEF_W-1:0]);
			REG_SIN_AXIAL:   m_sin_ax  = coef_t'(d[COEF_W-1:0]);
			REG_CENTER_X:    m_cx      = d;
			REG_CENTER_Y:    m_cy      = d;
			REG_PIVOT_Z:     m_pz      = d;
			default: ;
		endcase
	endtask

	// --------------------------------------------------------------- driver
	always @(posedge clk or negedge arst_n) begin
		logic  nxt_start;
		logic  nxt_we;
		beat_t it;
		if (!arst_n) begin
			start    <= 1'b0;
			cfg_we   <= 1'b0;
			gap_left = 0;
			gap_done = 1'b0;
		end else begin
			if (cfg_we) begin
				apply_write(cfg_idx, cfg_wdata);
			end
			if (start && !busy) begin
				rot_expect_q.push_back(rotate_point(line_x, line_y, slice_z));
				n_points++;
				since_beat = 0;
			end else if (since_beat < DRAIN) begin
				since_beat++;
			end
			nxt_start = start && busy;
			nxt_we    = 1'b0;
			if (!nxt_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (feed_q.size() > 0) begin
					it = feed_q[0];
					if (it.is_cfg) begin
						if (since_beat >= DRAIN && rot_expect_q.size() == 0) begin
							void'(feed_q.pop_front());
							nxt_we = 1'b1;
							cfg_idx   <= it.idx;
							cfg_wdata <= it.wdata;
							n_writes++;
						end
					end else if (it.pre_gap > 0 && !gap_done) begin
						gap_left = it.pre_gap - 1;
						gap_done = 1'b1;
					end else begin
						void'(feed_q.pop_front());
						gap_done  = 1'b0;
						nxt_start = 1'b1;
						line_x  <= it.lx;
						line_y  <= it.ly;
						slice_z <= it.sz;
					end
				end
			end
			start  <= nxt_start;
			cfg_we <= nxt_we;
		end
	end

	// -------------------------------------------------------------- monitor
	task automatic report_mismatch(input string msg);
		if (n_errors < PRINT_CAP) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
		n_errors++;
	endtask

	task automatic check_coord(input string name, input out_t got, input out_t want);
		if (got !== want) begin
			report_mismatch($sformatf("beat %0d %s got %0d want %0d", n_results, name, got, want));
		end
	endtask

	always @(posedge clk) begin
		coord_t e;
		if (arst_n && done) begin
			if (rot_expect_q.size() == 0) begin
				report_mismatch($sformatf("result beat %0d with nothing expected", n_results));
			end else begin
				e = rot_expect_q.pop_front();
				check_coord("rot_x", rot_x, e.x);
				check_coord("rot_y", rot_y, e.y);
				check_coord("rot_z", rot_z, e.z);
			end
			n_results++;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------- stimulus
	task automatic add_point(input line_t lx, input line_t ly, input slice_t sz,
			input int unsigned gap);
		beat_t b;
		b.is_cfg  = 1'b0;
		b.idx     = '0;
		b.wdata   = '0;
		b.lx      = lx;
		b.ly      = ly;
		b.sz      = sz;
		b.pre_gap = gap;
		feed_q.push_back(b);
	endtask

	task automatic add_write(input logic [2:0] idx, input cfg_data_t d);
		beat_t b;
		b.is_cfg  = 1'b1;
		b.idx     = idx;
		b.wdata   = d;
		b.lx      = '0;
		b.ly      = '0;
		b.sz      = '0;
		b.pre_gap = 0;
		feed_q.push_back(b);
	endtask

	// upper data bits above the coefficient width are junk on purpose
	task automatic set_angles(input coef_t cc, input coef_t sc, input coef_t ca, input coef_t sa);
		add_write(REG_COS_CORONAL, {2'($urandom), cc});
		add_write(REG_SIN_CORONAL, {2'($urandom), sc});
		add_write(REG_COS_AXIAL, {2'($urandom), ca});
		add_write(REG_SIN_AXIAL, {2'($urandom), sa});
	endtask

	task automatic set_pivot(input pos_t cx, input pos_t cy, input pos_t pz);
		add_write(REG_CENTER_X, cx);
		add_write(REG_CENTER_Y, cy);
		add_write(REG_PIVOT_Z, pz);
	endtask

	function automatic coef_t pick_coef(input int mode);
		case (mode)
			0: return coef_t'($urandom);
			1: begin
				case ($urandom_range(0, 5))
					0: return -16'sd32768;
					1: return 16'sd32767;
					2: return -16'sd16384;
					3: return 16'sd16384;
					4: return 16'sd0;
					default: return coef_t'($urandom_range(0, 1) ? 1 : -1);
				endcase
			end
			default: return coef_t'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	function automatic coef_t trig_q14(input real v);
		return coef_t'($rtoi($floor(v * 16384.0 + 0.5)));
	endfunction

	task automatic random_setting(input int mode);
		real ang_c, ang_a;
		ang_c = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
		ang_a = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
		if (mode == 2) begin
			set_angles(trig_q14($cos(ang_c)), trig_q14($sin(ang_c)),
				trig_q14($cos(ang_a)), trig_q14($sin(ang_a)));
		end else begin
			set_angles(pick_coef(mode), pick_coef(mode), pick_coef(mode), pick_coef(mode));
		end
		if ($urandom_range(0, 2) == 0) begin
			set_pivot(pos_t'($urandom), pos_t'($urandom), pos_t'($urandom));
		end else begin
			set_pivot(pos_t'($urandom_range(0, 131072)), pos_t'($urandom_range(0, 131072)),
				pos_t'($urandom_range(0, 1023) * 256));
		end
	endtask

	function automatic line_t line_extreme();
		case ($urandom_range(0, 4))
			0: return -19'sd262144;
			1: return 19'sd262143;
			2: return 19'sd0;
			3: return -19'sd1;
			default: return 19'sd1;
		endcase
	endfunction

	task automatic add_random_point(input int unsigned gap);
		int unsigned kind;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			add_point(line_t'($urandom), line_t'($urandom), slice_t'($urandom), gap);
		end else if (kind == 1) begin
			add_point(line_extreme(), line_extreme(),
				slice_t'($urandom_range(0, 1) ? 2047 : -2048), gap);
		end else begin
			add_point(line_t'($urandom_range(0, 66000) - 500),
				line_t'($urandom_range(0, 66000) - 500),
				slice_t'($urandom_range(0, 1033) - 5), gap);
		end
	endtask

	initial begin
		int unsigned gap;
		int unsigned gap_pct;

		// reset settings: identity angles, pivot at the image center
		add_point(19'sd0, 19'sd0, 12'sd0, 0);
		add_point(-19'sd262144, -19'sd262144, -12'sd2048, 0);
		add_point(19'sd262143, 19'sd262143, 12'sd2047, 0);
		add_point(19'sd32768, 19'sd32768, -12'sd5, 0);
		add_point(19'sd12345, -19'sd1, 12'sd1028, 0);

		// unused index must leave everything alone
		add_write(IDX_SPARE, 18'h3FFFF);
		add_point(19'sd255, 19'sd257, 12'sd3, 0);

		// coefficients beyond unity, pivot at the far corner: saturation
		set_angles(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
		set_pivot(18'h3FFFF, 18'h00000, 18'h3FFFF);
		add_point(-19'sd262144, 19'sd262143, -12'sd2048, 0);
		add_point(19'sd262143, -19'sd262144, 12'sd2047, 1);
		add_point(19'sd0, 19'sd0, 12'sd1028, 0);
		add_point(19'sd1, -19'sd1, -12'sd5, 3);

		// quarter turns with the pivot at the origin
		set_angles(16'sd0, 16'sd16384, 16'sd0, -16'sd16384);
		set_pivot(18'h00000, 18'h00000, 18'h00000);
		add_point(19'sd256, 19'sd512, 12'sd1, 0);
		add_point(-19'sd262144, 19'sd262143, 12'sd1024, 0);
		add_point(19'sd262143, 19'sd262143, -12'sd2048, 0);

		// 45 degrees, odd offsets hit exact halves in the rounding
		set_angles(16'sd11585, 16'sd11585, 16'sd11585, -16'sd11585);
		set_pivot(18'd32768, 18'd32768, 18'd131072);
		add_point(19'sd32769, 19'sd32767, 12'sd512, 0);
		add_point(19'sd40960, 19'sd24576, 12'sd513, 2);
		add_point(19'sd32768, 19'sd32768, 12'sd512, 0);
		add_point(-19'sd1, 19'sd65535, -12'sd1, 0);

		for (int p = 0; p < N_PHASES; p++) begin
			random_setting(p % 3 == 0 ? 2 : (p % 3 == 1 ? int'($urandom_range(0, 2)) : p % 2));
			gap_pct = (p % 4 == 3 || p == N_PHASES - 1) ? 0 : 30;
			for (int i = 0; i < PHASE_PTS; i++) begin
				gap = ($urandom_range(1, 100) <= gap_pct) ? $urandom_range(1, 8) : 0;
				add_random_point(gap);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (feed_q.size() != 0 || start);
		while (rot_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (rot_expect_q.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never came", rot_expect_q.size()));
		end
		$display("sent %0d points and %0d register writes, checked %0d result beats",
			n_points, n_writes, n_results);
		$display("settings: reset, corners, quarter and eighth turns, %0d random phases",
			N_PHASES);
		if (n_errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
